// ===== rtl/core/gps_pkg.sv =====
// Shared types, codes and defaults for the graph path search block.
`timescale 1ns / 1ps
`default_nettype none
package gps_pkg;

  localparam int NUM_VERTICES_DEF = 8;
  localparam int STACK_DEPTH_DEF  = 32;
  localparam int MAX_RESULTS      = 29;

  localparam int OP_W   = 2;
  localparam int VERT_W = 3;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [OP_W-1:0] OP_ADD_EDGE = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR    = 2'd1;
  localparam logic [OP_W-1:0] OP_FIND     = 2'd2;

  // register index, taken from paddr[2]
  localparam logic REG_SHORTCUT = 1'b0;

  typedef struct packed {
    logic adj_add;
    logic adj_clear;
    logic search_init;
    logic follow;
    logic col_inc;
    logic pop;
    logic pop_load;
    logic push_finish;
    logic emit_rd;
    logic emit_latch;
    logic srch_rd;
    logic srch_next;
    logic out_load;
    logic use_j;
    logic out_fail;
    logic advance;
  } dp_cmd_t;

  typedef struct packed {
    logic range_ok;
    logic at_finish;
    logic edge_bit;
    logic col_last;
    logic count_zero;
    logic limit_hit;
    logic match;
    logic out_last;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/gps_ctrl.sv =====
// Sequencer for the path search: edge updates, scan/backtrack, result emission.
`timescale 1ns / 1ps
`default_nettype none
module gps_ctrl (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  input  wire logic [gps_pkg::OP_W-1:0] op_i,
  input  wire logic                    out_stall_i,
  input  wire logic                    shortcut_i,
  input  wire gps_pkg::dp_status_t     status_i,
  output gps_pkg::dp_cmd_t             cmd_o,
  output logic                         in_stall_o,
  output logic                         out_valid_o
);
  import gps_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_POPW    = 3'd2;
  localparam logic [2:0] S_EMIT_RD = 3'd3;
  localparam logic [2:0] S_EMIT_W  = 3'd4;
  localparam logic [2:0] S_SRCH_RD = 3'd5;
  localparam logic [2:0] S_SRCH_W  = 3'd6;
  localparam logic [2:0] S_OUT     = 3'd7;

  logic [2:0] state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (op_i)
            OP_ADD_EDGE: cmd_o.adj_add = 1'b1;
            OP_CLEAR:    cmd_o.adj_clear = 1'b1;
            OP_FIND: begin
              if (status_i.range_ok) begin
                cmd_o.search_init = 1'b1;
                state_d           = S_SCAN;
              end else begin
                cmd_o.out_fail = 1'b1;
                state_d        = S_OUT;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (status_i.at_finish) begin
          cmd_o.push_finish = 1'b1;
          state_d           = S_EMIT_RD;
        end else if (status_i.edge_bit) begin
          if (status_i.limit_hit) begin
            cmd_o.out_fail = 1'b1;
            state_d        = S_OUT;
          end else begin
            cmd_o.follow = 1'b1;
          end
        end else if (status_i.col_last) begin
          if (status_i.count_zero) begin
            cmd_o.out_fail = 1'b1;
            state_d        = S_OUT;
          end else begin
            cmd_o.pop = 1'b1;
            state_d   = S_POPW;
          end
        end else begin
          cmd_o.col_inc = 1'b1;
        end
      end
      S_POPW: begin
        cmd_o.pop_load = 1'b1;
        state_d        = S_SCAN;
      end
      S_EMIT_RD: begin
        cmd_o.emit_rd = 1'b1;
        state_d       = S_EMIT_W;
      end
      S_EMIT_W: begin
        cmd_o.emit_latch = 1'b1;
        if (shortcut_i) begin
          state_d = S_SRCH_RD;
        end else begin
          cmd_o.out_load = 1'b1;
          state_d        = S_OUT;
        end
      end
      S_SRCH_RD: begin
        cmd_o.srch_rd = 1'b1;
        state_d       = S_SRCH_W;
      end
      S_SRCH_W: begin
        if (status_i.match) begin
          cmd_o.out_load = 1'b1;
          cmd_o.use_j    = 1'b1;
          state_d        = S_OUT;
        end else begin
          cmd_o.srch_next = 1'b1;
          state_d         = S_SRCH_RD;
        end
      end
      S_OUT: begin
        if (!out_stall_i) begin
          if (status_i.out_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.advance = 1'b1;
            state_d       = S_EMIT_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

endmodule
`default_nettype wire

// ===== rtl/core/gps_datapath.sv =====
// Graph storage, work matrix, path stack memory and result registers.
`timescale 1ns / 1ps
`default_nettype none
module gps_datapath #(
  parameter int NUM_VERTICES = gps_pkg::NUM_VERTICES_DEF,
  parameter int STACK_DEPTH  = gps_pkg::STACK_DEPTH_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [gps_pkg::VERT_W-1:0] vertex_a_i,
  input  wire logic [gps_pkg::VERT_W-1:0] vertex_b_i,
  input  wire gps_pkg::dp_cmd_t          cmd_i,
  output gps_pkg::dp_status_t            status_o,
  output logic [gps_pkg::VERT_W-1:0]     vertex_o,
  output logic                           found_o,
  output logic                           last_o
);
  import gps_pkg::*;

  localparam int VW = $clog2(NUM_VERTICES);
  localparam int SW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int LIMIT = (STACK_DEPTH - 1 < MAX_RESULTS - 1) ? STACK_DEPTH - 1
                                                             : MAX_RESULTS - 1;

  logic [NUM_VERTICES-1:0] adj_q  [NUM_VERTICES];
  logic [NUM_VERTICES-1:0] work_q [NUM_VERTICES];
  logic [VW-1:0]           stack_mem [STACK_DEPTH];

  logic [VW-1:0] row_q, col_q, fin_q, v_q, rd_q;
  logic [CW-1:0] cnt_q, cnt_dec;
  logic [SW-1:0] p_q, j_q, h_q, pos, rd_addr;
  logic [VERT_W-1:0] vertex_q;
  logic found_q, last_q;

  logic [VW-1:0] a_idx, b_idx;
  logic a_ok, b_ok, add_ok, wr_en;

  assign a_idx   = VW'(vertex_a_i);
  assign b_idx   = VW'(vertex_b_i);
  assign a_ok    = 32'(vertex_a_i) < NUM_VERTICES;
  assign b_ok    = 32'(vertex_b_i) < NUM_VERTICES;
  assign add_ok  = a_ok && b_ok && (vertex_a_i != vertex_b_i);
  assign cnt_dec = cnt_q - CW'(1);
  assign pos     = cmd_i.use_j ? j_q : p_q;
  assign wr_en   = cmd_i.follow || cmd_i.push_finish;
  assign rd_addr = cmd_i.pop ? cnt_dec[SW-1:0] : (cmd_i.srch_rd ? j_q : p_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adj_q <= '{default: '0};
    end else if (cmd_i.adj_clear) begin
      adj_q <= '{default: '0};
    end else if (cmd_i.adj_add && add_ok) begin
      adj_q[a_idx][b_idx] <= 1'b1;
      adj_q[b_idx][a_idx] <= 1'b1;
    end
  end

  // search registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.search_init) begin
      work_q <= adj_q;
      row_q  <= a_idx;
      fin_q  <= b_idx;
      col_q  <= '0;
    end else if (cmd_i.follow) begin
      work_q[row_q][col_q] <= 1'b0;
      work_q[col_q][row_q] <= 1'b0;
      row_q <= col_q;
      col_q <= '0;
    end else if (cmd_i.col_inc) begin
      col_q <= col_q + VW'(1);
    end else if (cmd_i.pop_load) begin
      row_q <= rd_q;
      col_q <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.search_init) begin
      cnt_q <= '0;
    end else if (wr_en) begin
      cnt_q <= cnt_q + CW'(1);
    end else if (cmd_i.pop) begin
      cnt_q <= cnt_dec;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      stack_mem[cnt_q[SW-1:0]] <= row_q;
    end
    rd_q <= stack_mem[rd_addr];
  end

  // emission pointers
  always_ff @(posedge clk_i) begin
    if (cmd_i.push_finish) begin
      p_q <= '0;
    end else if (cmd_i.advance) begin
      p_q <= h_q + SW'(1);
    end
    if (cmd_i.emit_latch) begin
      v_q <= rd_q;
      j_q <= cnt_dec[SW-1:0];
    end else if (cmd_i.srch_next) begin
      j_q <= j_q - SW'(1);
    end
    if (cmd_i.out_load) begin
      h_q      <= pos;
      vertex_q <= VERT_W'(rd_q);
      found_q  <= 1'b1;
      last_q   <= (CW'(pos) + CW'(1)) == cnt_q;
    end else if (cmd_i.out_fail) begin
      vertex_q <= '0;
      found_q  <= 1'b0;
      last_q   <= 1'b1;
    end
  end

  always_comb begin
    status_o.range_ok   = a_ok && b_ok;
    status_o.at_finish  = (row_q == fin_q);
    status_o.edge_bit   = work_q[row_q][col_q];
    status_o.col_last   = (col_q == VW'(NUM_VERTICES - 1));
    status_o.count_zero = (cnt_q == '0);
    status_o.limit_hit  = 32'(cnt_q) >= LIMIT;
    status_o.match      = (rd_q == v_q);
    status_o.out_last   = last_q;
  end

  assign vertex_o = vertex_q;
  assign found_o  = found_q;
  assign last_o   = last_q;

endmodule
`default_nettype wire

// ===== rtl/core/graph_path_search_dfs.sv =====
// Top level: depth-first path search over an adjacency bit matrix.
// Add edge / clear graph: done in idle, no result transfer; these go back to back.
// Path query: a setup step, a scan step per column, a stack memory read per backtrack
// and a push of the finish vertex. Then each result is read from the stack, latched
// and offered, held while the result is stalled.
// Loop erasure adds a stack read and compare per entry probed from the top down per result.
// Next item is taken the cycle after the final result transfer.
// Reset (async, active low) empties the graph and clears shortcut mode; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module graph_path_search_dfs #(
  parameter int NUM_VERTICES = gps_pkg::NUM_VERTICES_DEF,
  parameter int STACK_DEPTH  = gps_pkg::STACK_DEPTH_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // item channel
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [gps_pkg::OP_W-1:0]    op_i,
  input  wire logic [gps_pkg::VERT_W-1:0]  vertex_a_i,
  input  wire logic [gps_pkg::VERT_W-1:0]  vertex_b_i,
  // result channel
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [gps_pkg::VERT_W-1:0]       vertex_o,
  output logic                             found_o,
  output logic                             last_o,
  // register port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [gps_pkg::APB_AW-1:0]  paddr,
  input  wire logic [gps_pkg::APB_DW-1:0]  pwdata,
  output logic [gps_pkg::APB_DW-1:0]       prdata,
  output logic                             pready
);
  import gps_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       shortcut_q;

  // Register file: one bit, word index in paddr[2]; writes elsewhere are dropped.
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shortcut_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_SHORTCUT)) begin
      shortcut_q <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == REG_SHORTCUT) ? {{(APB_DW-1){1'b0}}, shortcut_q} : '0;

  // Sequencer: owns the handshakes; the datapath only answers status.
  gps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .op_i        (op_i),
    .out_stall_i (out_stall_i),
    .shortcut_i  (shortcut_q),
    .status_i    (status),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  // Matrices, path stack and result registers.
  gps_datapath #(
    .NUM_VERTICES (NUM_VERTICES),
    .STACK_DEPTH  (STACK_DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .vertex_a_i (vertex_a_i),
    .vertex_b_i (vertex_b_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .vertex_o   (vertex_o),
    .found_o    (found_o),
    .last_o     (last_o)
  );

  // A pending result transfer always holds off new items.
  a_busy_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("item channel open while result pending");

  // Failure result is a lone vertex zero.
  a_fail_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (last_o && (vertex_o == '0)))
    else $error("malformed failure result");

  // Edge updates produce no result.
  a_no_result_on_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (op_i != OP_FIND)) |=> !out_valid_o)
    else $error("result after edge update");

  // Once the final result transfers, the block goes idle.
  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_o) |=> (!out_valid_o && !in_stall_o))
    else $error("not idle after final result");

endmodule
`default_nettype wire

// ===== test/tb_graph_path_search_dfs.sv =====
// Self-checking testbench for graph_path_search_dfs: directed, random and backpressure tests.
`timescale 1ns / 1ps
module tb_graph_path_search_dfs;
  import gps_pkg::*;

  localparam int CLK_PERIOD     = 20;
  localparam int RESET_CYCLES   = 12;
  // Bound on the whole run; the slowest query is a full search plus 29 results
  // with loop erasure and stalls.
  localparam int TIMEOUT_CYCLES = 1_200_000;
  // Quiet time before register accesses; the block is idle right after its last result.
  localparam int SETTLE_CYCLES  = 300;
  localparam int HOLD_CYCLES    = 400;

  localparam int NV    = NUM_VERTICES_DEF;
  localparam int DEPTH = STACK_DEPTH_DEF;

  // op 3 has no name in the package; the block drops it.
  localparam logic [OP_W-1:0]   OP_UNUSED     = 2'd3;
  localparam logic [APB_AW-1:0] SHORTCUT_ADDR = {REG_SHORTCUT, 2'b00};

  typedef struct packed {
    logic [VERT_W-1:0] vertex;
    logic              found;
    logic              last;
  } hop_t;

  // DUT ports
  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [OP_W-1:0]   op_i;
  logic [VERT_W-1:0] vertex_a_i;
  logic [VERT_W-1:0] vertex_b_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [VERT_W-1:0] vertex_o;
  logic              found_o;
  logic              last_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  // Predictor state: the graph as the block should hold it, and the mode bit.
  logic [NV-1:0] adjacency [NV];
  bit            shortcut_on;

  // Hops still owed by the block, oldest first.
  hop_t expected_hops[$];

  // Traffic control
  bit   idle_en;      // random gaps on both channels
  bit   hold_on;      // long output hold-off, owned by the hold process
  event hold_ev;
  int   stall_left;

  // Bookkeeping
  int errors;
  int items_done;
  int queries;
  int paths_found;
  int paths_failed;
  int hops_checked;
  int in_stall_cycles;

  graph_path_search_dfs u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .vertex_a_i  (vertex_a_i),
    .vertex_b_i  (vertex_b_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .vertex_o    (vertex_o),
    .found_o     (found_o),
    .last_o      (last_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial clk_i = 1'b0;
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ------------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------------

  // Appends one owed hop at the tail of the queue.
  task automatic owe_hop(input hop_t h);
    expected_hops = {expected_hops, h};
  endtask

  // Depth-first search on a scratch copy of the graph. Each followed edge is
  // removed both ways and the row pushed; a dead row pops back and rescans
  // from column zero. The finish vertex closes the trail.
  task automatic trace_path(input logic [VERT_W-1:0] start,
                            input logic [VERT_W-1:0] finish);
    logic [NV-1:0]     work [NV];
    logic [VERT_W-1:0] trail [DEPTH];
    int                depth, row, col, limit, hit, gap, i, j;
    bit                ok;
    hop_t              h;
    limit = (DEPTH - 1 < MAX_RESULTS - 1) ? DEPTH - 1 : MAX_RESULTS - 1;
    ok    = (int'(start) < NV) && (int'(finish) < NV);
    depth = 0;
    row   = start;
    col   = 0;
    for (i = 0; i < NV; i++) work[i] = adjacency[i];
    while (ok && row != int'(finish)) begin
      if (work[row][col]) begin
        // no room left for the finish vertex: the query fails
        if (depth >= limit) begin
          ok = 1'b0;
        end else begin
          work[row][col] = 1'b0;
          work[col][row] = 1'b0;
          trail[depth]   = VERT_W'(row);
          depth++;
          row = col;
          col = 0;
        end
      end else if (col == NV - 1) begin
        if (depth == 0) begin
          ok = 1'b0;
        end else begin
          depth--;
          row = trail[depth];
          col = 0;
        end
      end else begin
        col++;
      end
    end
    if (ok) begin
      trail[depth] = finish;
      depth++;
    end
    // Loop erasure: cut from each position up to just before the last repeat.
    if (ok && shortcut_on) begin
      i = 0;
      while (i < depth) begin
        hit = i;
        for (j = i + 1; j < depth; j++)
          if (trail[j] == trail[i]) hit = j;
        if (hit > i) begin
          gap = hit - i;
          for (j = i; j + gap < depth; j++) trail[j] = trail[j + gap];
          depth -= gap;
        end
        i++;
      end
    end
    queries++;
    if (!ok) begin
      paths_failed++;
      h.vertex = '0;
      h.found  = 1'b0;
      h.last   = 1'b1;
      owe_hop(h);
    end else begin
      paths_found++;
      for (i = 0; i < depth; i++) begin
        h.vertex = trail[i];
        h.found  = 1'b1;
        h.last   = (i == depth - 1);
        owe_hop(h);
      end
    end
  endtask

  // Applies one accepted item to the graph model and queues any hops it owes.
  task automatic apply_item(input logic [OP_W-1:0] op, input logic [VERT_W-1:0] a,
                            input logic [VERT_W-1:0] b);
    int i;
    case (op)
      OP_ADD_EDGE: begin
        // self loops and out-of-range vertices leave the graph alone
        if (a != b && int'(a) < NV && int'(b) < NV) begin
          adjacency[a][b] = 1'b1;
          adjacency[b][a] = 1'b1;
          items_done++;
        end
      end
      OP_CLEAR: begin
        for (i = 0; i < NV; i++) adjacency[i] = '0;
        items_done++;
      end
      OP_FIND: begin
        trace_path(a, b);
        items_done++;
      end
      default: ;
    endcase
  endtask

  // ------------------------------------------------------------------------
  // Item channel driver
  // ------------------------------------------------------------------------

  // Offers one item from a falling edge and holds it until a transfer. The
  // optional gap is drawn before the item, never in reaction to stall.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [VERT_W-1:0] a,
                           input logic [VERT_W-1:0] b);
    @(negedge clk_i);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    op_i       = op;
    vertex_a_i = a;
    vertex_b_i = b;
    do @(posedge clk_i); while (in_stall_o);
    apply_item(op, a, b);
  endtask

  // Lowers valid and waits until every owed hop has come back, then lets the
  // block finish any trailing add/clear work before registers are touched.
  task automatic quiesce();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_hops.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One APB transfer: setup phase, then access phase until pready.
  task automatic reg_access(input bit wr, input logic [APB_DW-1:0] wdata,
                            output logic [APB_DW-1:0] rdata);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = SHORTCUT_ADDR;
    pwdata  = wdata;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    if (wr) shortcut_on = wdata[0];
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Changes shortcut mode with the block idle and reads it back.
  task automatic set_shortcut(input bit mode);
    logic [APB_DW-1:0] wdata, rdata;
    quiesce();
    wdata    = $urandom();
    wdata[0] = mode;
    reg_access(1'b1, wdata, rdata);
    reg_access(1'b0, '0, rdata);
    if (rdata[0] !== mode) begin
      $error("shortcut_mode: expected %0d, got %0d", mode, rdata[0]);
      errors++;
    end
  endtask

  // Lays a random simple chain through the vertices, plus some stray edges
  // (self loops among them), and hands back the chain ends.
  task automatic build_graph(input int extras, output logic [VERT_W-1:0] head,
                             output logic [VERT_W-1:0] tail);
    logic [VERT_W-1:0] order [NV];
    logic [VERT_W-1:0] t;
    int                i, k, len;
    for (i = 0; i < NV; i++) order[i] = VERT_W'(i);
    for (i = NV - 1; i > 0; i--) begin
      k        = $urandom_range(0, i);
      t        = order[i];
      order[i] = order[k];
      order[k] = t;
    end
    len = $urandom_range(1, NV - 1);
    for (i = 0; i < len; i++) send_item(OP_ADD_EDGE, order[i], order[i + 1]);
    repeat (extras)
      send_item(OP_ADD_EDGE, VERT_W'($urandom_range(0, NV - 1)),
                VERT_W'($urandom_range(0, NV - 1)));
    head = order[0];
    tail = order[len];
  endtask

  // Clear, build, then ask for the chain plus a few arbitrary pairs.
  task automatic query_burst(input int extras);
    logic [VERT_W-1:0] head, tail;
    send_item(OP_CLEAR, VERT_W'($urandom_range(0, 7)), VERT_W'($urandom_range(0, 7)));
    build_graph(extras, head, tail);
    if ($urandom_range(0, 1)) send_item(OP_FIND, head, tail);
    else send_item(OP_FIND, tail, head);
    repeat ($urandom_range(0, 2))
      send_item(OP_FIND, VERT_W'($urandom_range(0, 7)), VERT_W'($urandom_range(0, 7)));
  endtask

  // ------------------------------------------------------------------------
  // Result channel: stall generation and checking
  // ------------------------------------------------------------------------

  // Long hold-off, counted here so the sender can keep offering meanwhile.
  // hold_on only changes on rising edges; the stall driver reads it on falling.
  initial begin
    hold_on = 1'b0;
    forever begin
      @(hold_ev);
      hold_on = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      hold_on = 1'b0;
    end
  end

  always @(negedge clk_i) begin
    if (hold_on) begin
      out_stall_i = 1'b1;
    end else if (stall_left > 0) begin
      out_stall_i = 1'b1;
      stall_left--;
    end else if (idle_en && $urandom_range(0, 4) == 0) begin
      // start a stall burst of random length
      out_stall_i = 1'b1;
      stall_left  = $urandom_range(0, 2);
    end else begin
      out_stall_i = 1'b0;
    end
  end

  // Every result transfer is matched against the oldest owed hop.
  always @(posedge clk_i) begin
    hop_t want;
    if (rst_ni && in_valid_i && in_stall_o) in_stall_cycles++;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_hops.size() == 0) begin
        $error("unexpected result: vertex %0d found %0d last %0d", vertex_o, found_o, last_o);
        errors++;
      end else begin
        want = expected_hops.pop_front();
        hops_checked++;
        if (vertex_o !== want.vertex) begin
          $error("vertex: expected %0d, got %0d", want.vertex, vertex_o);
          errors++;
        end
        if (found_o !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, found_o);
          errors++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last_o);
          errors++;
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------

  // Empty graph, start equal to finish, ignored items, field extremes.
  task automatic test_trivial_queries();
    send_item(OP_FIND, 3'd0, 3'd7);      // nothing to walk: failure result
    send_item(OP_FIND, 3'd7, 3'd7);      // start is finish: one hop
    send_item(OP_ADD_EDGE, 3'd3, 3'd3);  // self loop, dropped
    send_item(OP_UNUSED, 3'd7, 3'd7);    // unused op, dropped
    send_item(OP_UNUSED, 3'd0, 3'd0);
    send_item(OP_FIND, 3'd3, 3'd4);      // still no edge at 3
    send_item(OP_ADD_EDGE, 3'd0, 3'd7);
    send_item(OP_FIND, 3'd7, 3'd0);
    send_item(OP_FIND, 3'd0, 3'd7);
  endtask

  // Triangle 0-1-2 hanging off 0 with a tail to 3: the walk 0 1 2 0 3
  // carries a loop that shortcut mode must cut down to 0 3.
  task automatic test_loop_erasure();
    set_shortcut(1'b0);
    send_item(OP_CLEAR, 3'd5, 3'd2);
    send_item(OP_ADD_EDGE, 3'd0, 3'd1);
    send_item(OP_ADD_EDGE, 3'd1, 3'd2);
    send_item(OP_ADD_EDGE, 3'd2, 3'd0);
    send_item(OP_ADD_EDGE, 3'd0, 3'd3);
    send_item(OP_FIND, 3'd0, 3'd3);
    set_shortcut(1'b1);
    send_item(OP_FIND, 3'd0, 3'd3);
    send_item(OP_FIND, 3'd3, 3'd2);      // loop-free walk, untouched
    send_item(OP_CLEAR, 3'd0, 3'd0);
    send_item(OP_FIND, 3'd0, 3'd3);      // cleared graph: failure
  endtask

  // Mostly well-formed clear/build/query bursts; the rest is stray items,
  // queries on leftover graphs and unused ops.
  task automatic test_random_searches(input int count, input bit mode);
    int first;
    int roll;
    set_shortcut(mode);
    idle_en = 1'b1;
    first   = items_done;
    while (items_done - first < count) begin
      roll = $urandom_range(0, 9);
      if (roll == 0) begin
        send_item(OP_UNUSED, VERT_W'($urandom_range(0, 7)), VERT_W'($urandom_range(0, 7)));
      end else if (roll <= 6) begin
        query_burst($urandom_range(0, 8));
      end else begin
        repeat ($urandom_range(1, 3))
          send_item(OP_W'($urandom_range(0, 3)), VERT_W'($urandom_range(0, 7)),
                    VERT_W'($urandom_range(0, 7)));
      end
    end
  endtask

  // Output held off for a long stretch while queries keep coming, so the
  // block backs up and stalls its input.
  task automatic test_backpressure();
    logic [VERT_W-1:0] head, tail;
    send_item(OP_CLEAR, 3'd1, 3'd6);
    build_graph(10, head, tail);
    -> hold_ev;
    repeat (6) send_item(OP_FIND, head, tail);
    repeat (6)
      send_item(OP_FIND, VERT_W'($urandom_range(0, 7)), VERT_W'($urandom_range(0, 7)));
  endtask

  // Closing stretch at full rate on both sides.
  task automatic test_steady_stream(input int count);
    int first;
    set_shortcut(1'b0);
    idle_en = 1'b0;
    first   = items_done;
    while (items_done - first < count) query_burst($urandom_range(2, 10));
  endtask

  // ------------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------------

  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    op_i            = OP_ADD_EDGE;
    vertex_a_i      = '0;
    vertex_b_i      = '0;
    out_stall_i     = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    idle_en         = 1'b1;
    stall_left      = 0;
    shortcut_on     = 1'b0;
    errors          = 0;
    items_done      = 0;
    queries         = 0;
    paths_found     = 0;
    paths_failed    = 0;
    hops_checked    = 0;
    in_stall_cycles = 0;
    for (int i = 0; i < NV; i++) adjacency[i] = '0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_trivial_queries();
    test_loop_erasure();
    test_random_searches(40, 1'b0);
    test_random_searches(40, 1'b1);
    test_backpressure();
    test_steady_stream(25);

    quiesce();
    $display("Run covered %0d items: %0d path queries, %0d found, %0d with no path.",
             items_done, queries, paths_found, paths_failed);
    $display("%0d result transfers checked with shortcut mode off and on; input stalled %0d cycles.",
             hops_checked, in_stall_cycles);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("TEST FAILED");
    $finish;
  end

endmodule
